[rtl/accumulator_cpu_step_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the accumulator CPU step block
// Shared property wrappers used by the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef ACCUMULATOR_CPU_STEP_DEFINES_SVH
`define ACCUMULATOR_CPU_STEP_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define ACS_ASSERT_NOW(lbl, clk, rstn, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the following cycle.
`define ACS_ASSERT_NEXT(lbl, clk, rstn, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
    else $error(msg);

`endif

[rtl/acs_pkg.sv]
// ----------------------------------------------------------------------------
// acs_pkg
// Types and constants of the accumulator CPU step block.
// ----------------------------------------------------------------------------
package acs_pkg;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_READ    = 2'd1,
    KIND_EXEC    = 2'd2,
    KIND_RESTART = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_HALT    = 3'd1,
    ST_BADOP   = 3'd2,
    ST_BADADDR = 3'd3,
    ST_IOERR   = 3'd4,
    ST_DIVZERO = 3'd5
  } status_t;

  localparam logic [4:0] OP_NOP  = 5'd0;
  localparam logic [4:0] OP_HALT = 5'd1;
  localparam logic [4:0] OP_LDI  = 5'd2;
  localparam logic [4:0] OP_LD   = 5'd3;
  localparam logic [4:0] OP_LDX  = 5'd4;
  localparam logic [4:0] OP_ST   = 5'd5;
  localparam logic [4:0] OP_STX  = 5'd6;
  localparam logic [4:0] OP_TAX  = 5'd7;
  localparam logic [4:0] OP_TXA  = 5'd8;
  localparam logic [4:0] OP_INX  = 5'd9;
  localparam logic [4:0] OP_ADD  = 5'd10;
  localparam logic [4:0] OP_SUB  = 5'd11;
  localparam logic [4:0] OP_MUL  = 5'd12;
  localparam logic [4:0] OP_DIV  = 5'd13;
  localparam logic [4:0] OP_REM  = 5'd14;
  localparam logic [4:0] OP_NEG  = 5'd15;
  localparam logic [4:0] OP_JMP  = 5'd16;
  localparam logic [4:0] OP_JZ   = 5'd17;
  localparam logic [4:0] OP_JNZ  = 5'd18;
  localparam logic [4:0] OP_IOR  = 5'd19;
  localparam logic [4:0] OP_IOW  = 5'd20;

  localparam logic [31:0] OP_LAST = 32'd20;

  // Request from the sequencer to the divider.
  typedef struct packed {
    logic start;
    logic want_rem;
  } div_req_t;

endpackage

[rtl/acs_in_if.sv]
// ----------------------------------------------------------------------------
// acs_in_if
// Input channel: one command word per handshake.
// ----------------------------------------------------------------------------
interface acs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [11:0]        address;
  logic signed [31:0] value;
  logic signed [31:0] io_read_value;
  logic               io_ok;

  modport source (output valid, kind, address, value, io_read_value, io_ok,
                  input ready);
  modport sink   (input valid, kind, address, value, io_read_value, io_ok,
                  output ready);
endinterface

[rtl/acs_out_if.sv]
// ----------------------------------------------------------------------------
// acs_out_if
// Result channel: one status word per handshake.
// ----------------------------------------------------------------------------
interface acs_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] error_detail;
  logic signed [31:0] pc_now;
  logic signed [31:0] acc_now;
  logic signed [31:0] index_now;
  logic signed [31:0] mem_read_data;
  logic signed [31:0] io_device;
  logic               io_read_strobe;
  logic               io_write_strobe;
  logic signed [31:0] io_write_value;

  modport source (output valid, status, error_detail, pc_now, acc_now, index_now,
                  mem_read_data, io_device, io_read_strobe, io_write_strobe,
                  io_write_value, input ready);
  modport sink   (input valid, status, error_detail, pc_now, acc_now, index_now,
                  mem_read_data, io_device, io_read_strobe, io_write_strobe,
                  io_write_value, output ready);
endinterface

[rtl/acs_mem.sv]
// ----------------------------------------------------------------------------
// acs_mem
// Single-port synchronous word memory with a registered read.
// ----------------------------------------------------------------------------
module acs_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[addr] <= wdata;
    end
    if (en && !we) begin
      rdata <= mem[addr];
    end
  end

endmodule

[rtl/acs_div.sv]
// ----------------------------------------------------------------------------
// acs_div
// Iterative signed 32-bit divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module acs_div (
  input  logic              clk,
  input  logic              rst_n,
  input  acs_pkg::div_req_t req,
  input  logic [31:0]       dividend,
  input  logic [31:0]       divisor,
  output logic              busy,
  output logic              done,
  output logic [31:0]       result
);
  import acs_pkg::*;

  logic        busy_r, done_r, rem_sel_r, neg_q_r, neg_r_r;
  logic [5:0]  cnt_r;
  logic [31:0] rem_r, quo_r, dvs_r, result_r;
  logic [32:0] shifted, diff;
  logic [31:0] rem_nxt, quo_nxt;

  assign shifted = {rem_r, quo_r[31]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    if (!diff[32]) begin
      rem_nxt = diff[31:0];
      quo_nxt = {quo_r[30:0], 1'b1};
    end else begin
      rem_nxt = shifted[31:0];
      quo_nxt = {quo_r[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r    <= 1'b1;
        cnt_r     <= 6'd32;
        rem_sel_r <= req.want_rem;
        neg_q_r   <= dividend[31] ^ divisor[31];
        neg_r_r   <= dividend[31];
        rem_r     <= '0;
        quo_r     <= dividend[31] ? (32'd0 - dividend) : dividend;
        dvs_r     <= divisor[31] ? (32'd0 - divisor) : divisor;
      end else if (busy_r) begin
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          if (rem_sel_r) begin
            result_r <= neg_r_r ? (32'd0 - rem_r) : rem_r;
          end else begin
            result_r <= neg_q_r ? (32'd0 - quo_r) : quo_r;
          end
        end else begin
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          cnt_r <= cnt_r - 6'd1;
        end
      end
    end
  end

  assign busy   = busy_r;
  assign done   = done_r;
  assign result = result_r;

endmodule

[rtl/accumulator_cpu_step.sv]
// ----------------------------------------------------------------------------
// accumulator_cpu_step
// Word-addressed accumulator CPU that handles one command word at a time.
// ----------------------------------------------------------------------------
// Each input word writes or reads one memory word, restarts the CPU at a given
// PC, or executes one instruction. The program and data live in a single-port
// synchronous memory of MEM_WORDS 32-bit words, and every instruction walks
// through it one access at a time: opcode fetch, then argument fetch and one
// data access where the opcode needs them. A host write, a restart or an
// execute word that meets an already latched error goes straight to the output
// stage; a host read first collects its registered read data. Divide and
// remainder use a radix-2 iterative divider. A new input word is accepted as
// soon as the previous one has been moved into the output register, even if
// that result is still waiting to be taken. Memory contents are undefined
// until written; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "accumulator_cpu_step_defines.svh"

module accumulator_cpu_step #(
  parameter int MEM_WORDS = 4096
) (
  input logic       clk,
  input logic       rst_n,
  acs_in_if.sink    in_ch,
  acs_out_if.source out_ch
);
  import acs_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  typedef enum logic [2:0] {
    S_IDLE, S_HRD, S_OP, S_ARG, S_DATA, S_DIV, S_DONE
  } state_t;

  // Architectural state.
  state_t      state_r, state_nxt;
  logic [31:0] pc_r, pc_nxt, acc_r, acc_nxt, x_r, x_nxt;
  status_t     err_r, err_nxt;
  logic [31:0] info_r, info_nxt;

  // Captured command fields.
  logic [31:0] iov_r, iov_nxt;
  logic        iook_r, iook_nxt;
  logic [4:0]  op_r, op_nxt;

  // Per-word side results.
  logic [31:0] rd_r, rd_nxt, dev_r, dev_nxt, wval_r, wval_nxt;
  logic        rstb_r, rstb_nxt, wstb_r, wstb_nxt;

  // Output register.
  logic        ov_r, ov_nxt;
  status_t     o_status_r, o_status_nxt;
  logic [31:0] o_info_r, o_info_nxt, o_pc_r, o_pc_nxt, o_acc_r, o_acc_nxt;
  logic [31:0] o_x_r, o_x_nxt, o_rd_r, o_rd_nxt, o_dev_r, o_dev_nxt;
  logic [31:0] o_wval_r, o_wval_nxt;
  logic        o_rstb_r, o_rstb_nxt, o_wstb_r, o_wstb_nxt;

  // Memory port.
  logic          mem_en, mem_we;
  logic [31:0]   mem_addr32, mem_wdata, mem_rdata;

  // Divider.
  div_req_t    div_req;
  logic        div_busy, div_done;
  logic [31:0] div_result;

  logic        in_accept;
  logic [31:0] host_addr, pc1, pc2, daddr;

  function automatic logic in_mem(input logic [31:0] a);
    return a < 32'(MEM_WORDS);
  endfunction

  acs_mem #(.DEPTH(MEM_WORDS), .AW(AW)) u_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr32[AW-1:0]),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  acs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (acc_r),
    .divisor  (mem_rdata),
    .busy     (div_busy),
    .done     (div_done),
    .result   (div_result)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign host_addr   = {20'd0, in_ch.address};
  assign pc1         = pc_r + 32'd1;
  assign pc2         = pc_r + 32'd2;
  // Indexed forms add X to the argument word, wrapping at 32 bits.
  assign daddr       = (op_r == OP_LDX || op_r == OP_STX) ? (mem_rdata + x_r) : mem_rdata;

  always_comb begin
    state_nxt    = state_r;
    pc_nxt       = pc_r;
    acc_nxt      = acc_r;
    x_nxt        = x_r;
    err_nxt      = err_r;
    info_nxt     = info_r;
    iov_nxt      = iov_r;
    iook_nxt     = iook_r;
    op_nxt       = op_r;
    rd_nxt       = rd_r;
    dev_nxt      = dev_r;
    wval_nxt     = wval_r;
    rstb_nxt     = rstb_r;
    wstb_nxt     = wstb_r;
    ov_nxt       = ov_r && !out_ch.ready;
    o_status_nxt = o_status_r;
    o_info_nxt   = o_info_r;
    o_pc_nxt     = o_pc_r;
    o_acc_nxt    = o_acc_r;
    o_x_nxt      = o_x_r;
    o_rd_nxt     = o_rd_r;
    o_dev_nxt    = o_dev_r;
    o_wval_nxt   = o_wval_r;
    o_rstb_nxt   = o_rstb_r;
    o_wstb_nxt   = o_wstb_r;
    mem_en       = 1'b0;
    mem_we       = 1'b0;
    mem_addr32   = '0;
    mem_wdata    = acc_r;
    div_req      = '{start: 1'b0, want_rem: 1'b0};

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          iov_nxt   = in_ch.io_read_value;
          iook_nxt  = in_ch.io_ok;
          rd_nxt    = '0;
          dev_nxt   = '0;
          wval_nxt  = '0;
          rstb_nxt  = 1'b0;
          wstb_nxt  = 1'b0;
          state_nxt = S_DONE;
          unique case (kind_t'(in_ch.kind))
            KIND_WRITE: begin
              if (in_mem(host_addr)) begin
                mem_en     = 1'b1;
                mem_we     = 1'b1;
                mem_addr32 = host_addr;
                mem_wdata  = in_ch.value;
              end
            end
            KIND_READ: begin
              if (in_mem(host_addr)) begin
                mem_en     = 1'b1;
                mem_addr32 = host_addr;
                state_nxt  = S_HRD;
              end
            end
            KIND_EXEC: begin
              if (err_r == ST_OK) begin
                if (!in_mem(pc_r)) begin
                  err_nxt  = ST_BADADDR;
                  info_nxt = pc_r;
                end else begin
                  mem_en     = 1'b1;
                  mem_addr32 = pc_r;
                  state_nxt  = S_OP;
                end
              end
            end
            KIND_RESTART: begin
              pc_nxt   = host_addr;
              acc_nxt  = '0;
              x_nxt    = '0;
              err_nxt  = ST_OK;
              info_nxt = '0;
            end
            default: ;
          endcase
        end
      end

      S_HRD: begin
        rd_nxt    = mem_rdata;
        state_nxt = S_DONE;
      end

      S_OP: begin
        state_nxt = S_DONE;
        op_nxt    = mem_rdata[4:0];
        if (mem_rdata > OP_LAST) begin
          err_nxt  = ST_BADOP;
          info_nxt = '0;
        end else begin
          unique case (mem_rdata[4:0])
            OP_NOP:  pc_nxt = pc1;
            OP_HALT: begin
              err_nxt  = ST_HALT;
              info_nxt = '0;
            end
            OP_TAX: begin x_nxt = acc_r; pc_nxt = pc1; end
            OP_TXA: begin acc_nxt = x_r; pc_nxt = pc1; end
            OP_INX: begin x_nxt = x_r + 32'd1; pc_nxt = pc1; end
            OP_NEG: begin acc_nxt = 32'd0 - acc_r; pc_nxt = pc1; end
            default: begin
              // Conditional jumps that fall through skip the argument word.
              if ((mem_rdata[4:0] == OP_JZ && acc_r != '0) ||
                  (mem_rdata[4:0] == OP_JNZ && acc_r == '0)) begin
                pc_nxt = pc2;
              end else if (!in_mem(pc1)) begin
                err_nxt  = ST_BADADDR;
                info_nxt = pc1;
              end else begin
                mem_en     = 1'b1;
                mem_addr32 = pc1;
                state_nxt  = S_ARG;
              end
            end
          endcase
        end
      end

      S_ARG: begin
        state_nxt = S_DONE;
        unique case (op_r)
          OP_LDI: begin acc_nxt = mem_rdata; pc_nxt = pc2; end
          OP_JMP, OP_JZ, OP_JNZ: pc_nxt = mem_rdata;
          OP_IOR: begin
            dev_nxt  = mem_rdata;
            rstb_nxt = 1'b1;
            if (!iook_r) begin
              err_nxt  = ST_IOERR;
              info_nxt = mem_rdata;
            end else begin
              acc_nxt = iov_r;
              pc_nxt  = pc2;
            end
          end
          OP_IOW: begin
            dev_nxt  = mem_rdata;
            wstb_nxt = 1'b1;
            wval_nxt = acc_r;
            if (!iook_r) begin
              err_nxt  = ST_IOERR;
              info_nxt = mem_rdata;
            end else begin
              pc_nxt = pc2;
            end
          end
          default: begin
            if (!in_mem(daddr)) begin
              err_nxt  = ST_BADADDR;
              info_nxt = daddr;
            end else if (op_r == OP_ST || op_r == OP_STX) begin
              mem_en     = 1'b1;
              mem_we     = 1'b1;
              mem_addr32 = daddr;
              pc_nxt     = pc2;
            end else begin
              mem_en     = 1'b1;
              mem_addr32 = daddr;
              state_nxt  = S_DATA;
            end
          end
        endcase
      end

      S_DATA: begin
        state_nxt = S_DONE;
        pc_nxt    = pc2;
        unique case (op_r)
          OP_ADD: acc_nxt = acc_r + mem_rdata;
          OP_SUB: acc_nxt = acc_r - mem_rdata;
          OP_MUL: acc_nxt = 32'(acc_r * mem_rdata);
          OP_DIV, OP_REM: begin
            pc_nxt = pc_r;
            if (mem_rdata == '0) begin
              err_nxt  = ST_DIVZERO;
              info_nxt = '0;
            end else begin
              div_req   = '{start: 1'b1, want_rem: (op_r == OP_REM)};
              state_nxt = S_DIV;
            end
          end
          default: acc_nxt = mem_rdata;
        endcase
      end

      S_DIV: begin
        if (div_done) begin
          acc_nxt   = div_result;
          pc_nxt    = pc2;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt       = 1'b1;
          o_status_nxt = err_r;
          o_info_nxt   = info_r;
          o_pc_nxt     = pc_r;
          o_acc_nxt    = acc_r;
          o_x_nxt      = x_r;
          o_rd_nxt     = rd_r;
          o_dev_nxt    = dev_r;
          o_wval_nxt   = wval_r;
          o_rstb_nxt   = rstb_r;
          o_wstb_nxt   = wstb_r;
          state_nxt    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
      acc_r   <= '0;
      x_r     <= '0;
      err_r   <= ST_OK;
      info_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      acc_r   <= acc_nxt;
      x_r     <= x_nxt;
      err_r   <= err_nxt;
      info_r  <= info_nxt;
      ov_r    <= ov_nxt;
    end
    iov_r      <= iov_nxt;
    iook_r     <= iook_nxt;
    op_r       <= op_nxt;
    rd_r       <= rd_nxt;
    dev_r      <= dev_nxt;
    wval_r     <= wval_nxt;
    rstb_r     <= rstb_nxt;
    wstb_r     <= wstb_nxt;
    o_status_r <= o_status_nxt;
    o_info_r   <= o_info_nxt;
    o_pc_r     <= o_pc_nxt;
    o_acc_r    <= o_acc_nxt;
    o_x_r      <= o_x_nxt;
    o_rd_r     <= o_rd_nxt;
    o_dev_r    <= o_dev_nxt;
    o_wval_r   <= o_wval_nxt;
    o_rstb_r   <= o_rstb_nxt;
    o_wstb_r   <= o_wstb_nxt;
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.status          = o_status_r;
  assign out_ch.error_detail    = o_info_r;
  assign out_ch.pc_now          = o_pc_r;
  assign out_ch.acc_now         = o_acc_r;
  assign out_ch.index_now       = o_x_r;
  assign out_ch.mem_read_data   = o_rd_r;
  assign out_ch.io_device       = o_dev_r;
  assign out_ch.io_read_strobe  = o_rstb_r;
  assign out_ch.io_write_strobe = o_wstb_r;
  assign out_ch.io_write_value  = o_wval_r;

  // The divider is never running while a new word can be accepted.
  `ACS_ASSERT_NOW(a_idle_div_quiet, clk, rst_n, in_ch.ready, !div_busy, "divider busy in idle")
  // A divider result only arrives while the sequencer waits for it.
  `ACS_ASSERT_NOW(a_div_done_state, clk, rst_n, div_done, state_r == S_DIV, "stray divide result")
  // A clean status never carries a detail value.
  `ACS_ASSERT_NOW(a_ok_no_detail, clk, rst_n, err_r == ST_OK, info_r == '0, "detail without error")
  // A divide always starts from the data state and lands in the divide wait.
  `ACS_ASSERT_NEXT(a_div_start, clk, rst_n, div_req.start, state_r == S_DIV, "divide start lost")

endmodule
